/* sv/pidaw_pkg.sv */
// Package: shared constants, types and codes for the PID controller block.
package pidaw_pkg;

  localparam int VALUE_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int TIME_WIDTH_DEF    = 24;

  localparam int MICROS_PER_SECOND = 1000000;
  localparam int TRAPEZOID_DIVISOR = 2;
  localparam int CFG_INDEX_WIDTH   = 3;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_KP              = 3'd0,
    REG_INTEGRAL_TIME   = 3'd1,
    REG_DERIVATIVE_TIME = 3'd2,
    REG_UPPER_LIMIT     = 3'd3,
    REG_LOWER_LIMIT     = 3'd4,
    REG_ANTI_WINDUP     = 3'd5
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P_MUL,
    ST_KD_MUL,
    ST_D_DIV,
    ST_CORR,
    ST_X_MUL,
    ST_I_DIV,
    ST_I_UPD,
    ST_DRIVE,
    ST_OUT
  } state_t;

  // Request to the shared serial divider.
  typedef struct packed {
    logic start;
    logic neg;
  } div_ctl_t;

endpackage

/* sv/pidaw_div.sv */
// Shared restoring divider: one quotient bit per cycle, rounds ties away, saturates.
module pidaw_div #(
  parameter int VALUE_WIDTH = pidaw_pkg::VALUE_WIDTH_DEF,
  parameter int NUM_WIDTH   = 128,
  parameter int DEN_WIDTH   = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pidaw_pkg::div_ctl_t           ctl,
  input  logic [NUM_WIDTH-1:0]          num,
  input  logic [DEN_WIDTH-1:0]          den,
  output logic                          done,
  output logic signed [VALUE_WIDTH-1:0] quo
);
  import pidaw_pkg::*;

  localparam int CW = $clog2(NUM_WIDTH + 1);
  localparam logic [NUM_WIDTH-1:0] VMAX_U =
    {{(NUM_WIDTH-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};

  logic [NUM_WIDTH-1:0] nreg;
  logic [NUM_WIDTH-1:0] q;
  logic [DEN_WIDTH:0]   r;
  logic [DEN_WIDTH-1:0] d;
  logic [CW-1:0]        cnt;
  logic                 busy;
  logic                 neg;
  logic [DEN_WIDTH:0]   r_sh;
  logic [DEN_WIDTH:0]   r_sub;
  logic [NUM_WIDTH-1:0] q_rnd;
  logic [NUM_WIDTH-1:0] lim;
  logic [DEN_WIDTH:0]   r_dbl;

  assign r_sh  = {r[DEN_WIDTH-1:0], nreg[NUM_WIDTH-1]};
  assign r_sub = r_sh - {1'b0, d};
  assign r_dbl = {r[DEN_WIDTH-1:0], 1'b0};
  assign q_rnd = q + ((r_dbl >= {1'b0, d}) ? NUM_WIDTH'(1) : NUM_WIDTH'(0));
  assign lim   = neg ? VMAX_U + NUM_WIDTH'(1) : VMAX_U;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_WIDTH);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      nreg <= num;
      d    <= den;
      neg  <= ctl.neg;
      q    <= '0;
      r    <= '0;
    end else if (busy) begin
      nreg <= {nreg[NUM_WIDTH-2:0], 1'b0};
      if (!r_sub[DEN_WIDTH]) begin
        r <= r_sub;
        q <= {q[NUM_WIDTH-2:0], 1'b1};
      end else begin
        r <= r_sh;
        q <= {q[NUM_WIDTH-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (q_rnd > lim) begin
      quo = neg ? {1'b1, {(VALUE_WIDTH-1){1'b0}}} : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    end else begin
      quo = neg ? -q_rnd[VALUE_WIDTH-1:0] : q_rnd[VALUE_WIDTH-1:0];
    end
  end

endmodule

/* sv/pidaw_mul.sv */
// Shift-add multiplier: one multiplier bit per cycle, unsigned magnitudes.
module pidaw_mul #(
  parameter int A_WIDTH = 64,
  parameter int B_WIDTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [A_WIDTH-1:0]         a,
  input  logic [B_WIDTH-1:0]         b,
  output logic                       done,
  output logic [A_WIDTH+B_WIDTH-1:0] prod
);
  localparam int CW = $clog2(B_WIDTH + 1);

  logic [A_WIDTH+B_WIDTH-1:0] acc;
  logic [A_WIDTH+B_WIDTH-1:0] sh;
  logic [B_WIDTH-1:0]         mb;
  logic [CW-1:0]              cnt;
  logic                       busy;

  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(B_WIDTH);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      sh  <= {{B_WIDTH{1'b0}}, a};
      mb  <= b;
    end else if (busy) begin
      if (mb[0]) acc <= acc + sh;
      sh <= {sh[A_WIDTH+B_WIDTH-2:0], 1'b0};
      mb <= {1'b0, mb[B_WIDTH-1:1]};
    end
  end

endmodule

/* sv/pid_controller_antiwindup.sv */
// Top level: PID controller with trapezoidal integral and back-calculation anti-windup.
//
// Channels: input items (func, measurement, setpoint, elapsed_us) on in_valid /
// in_ready; results (drive, proportional, integral, derivative, correction) on
// out_valid / out_ready. A transfer happens when valid and ready are both high.
// A shutdown item (func = 1) clears history and the integral and yields no result.
// Configuration: cfg_we, cfg_index, cfg_data; write only while idle. A write to a
// known index also clears the error/correction history.
// Sequencing: one item at a time. Each product/quotient term runs the bit-serial
// 64-bit multiplier and then the shared 128-bit divider; the derivative and
// integral quotients need a second multiply for the constant scale.
// Next item: accepted in the cycle after the result transfer, once back in idle.
// Reset: synchronous; loads kp = 1.0 and clears the other settings, the history,
// the integral, out_valid, the phase and the state. Working and result registers
// are not reset.
// Stall: a finished result waits in the output register until taken; no input is
// accepted meanwhile.
module pid_controller_antiwindup #(
  parameter int VALUE_WIDTH   = pidaw_pkg::VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS = pidaw_pkg::FRACTION_BITS_DEF,
  parameter int TIME_WIDTH    = pidaw_pkg::TIME_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pidaw_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [VALUE_WIDTH-1:0]        cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic signed [VALUE_WIDTH-1:0] measurement,
  input  logic signed [VALUE_WIDTH-1:0] setpoint,
  input  logic [TIME_WIDTH-1:0]         elapsed_us,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] drive,
  output logic signed [VALUE_WIDTH-1:0] proportional,
  output logic signed [VALUE_WIDTH-1:0] integral,
  output logic signed [VALUE_WIDTH-1:0] derivative,
  output logic signed [VALUE_WIDTH-1:0] correction
);
  import pidaw_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int WW = VW + 4;              // wide sums before clamping
  localparam int MW = 2 * VW;              // multiplier operand width
  localparam int PW = 2 * MW;              // product / dividend width
  localparam logic signed [WW-1:0] VMAX_W = WW'({1'b0, {(VW-1){1'b1}}});
  localparam logic signed [WW-1:0] VMIN_W = -VMAX_W - WW'(1);
  localparam logic [MW-1:0] MEGA = MW'(MICROS_PER_SECOND);
  localparam logic [MW-1:0] TWO_MEGA = MW'(TRAPEZOID_DIVISOR * MICROS_PER_SECOND);

  // Configuration registers.
  logic signed [VW-1:0] kp, upper_limit, lower_limit;
  logic [VW-2:0]        integral_time, derivative_time;
  logic                 anti_windup;

  // Controller state.
  logic                 have_previous;
  logic signed [VW-1:0] previous_error, previous_correction, integral_sum;

  // Per-item working registers.
  logic signed [VW-1:0] err, p, d, corr, kd;
  logic signed [VW+1:0] x;      // difference of three terms, needs two extra bits
  logic signed [VW:0]   de;
  logic [TIME_WIDTH-1:0] el;
  logic [MW-1:0]        den_r;  // Ti * 2e6 for the integral quotient
  logic [1:0]           phase;  // sub-step of a term: product, divide wait, second product
  state_t               state, state_next;

  // Derived combinational values.
  logic signed [VW-1:0] hi, lo;
  logic                 limiting, aw;
  logic signed [VW:0]   err_raw;
  logic signed [VW-1:0] err_sat;
  logic signed [WW-1:0] sum_w, isum_w, drive_w;
  logic signed [VW:0]   esum;

  // Serial units.
  logic                 m_start, m_done;
  logic [MW-1:0]        m_a, m_b;
  logic [PW-1:0]        m_prod;
  div_ctl_t             dctl;
  logic [PW-1:0]        d_num;
  logic [MW-1:0]        d_den;
  logic                 d_done;
  logic signed [VW-1:0] d_quo;
  logic                 sign_r;

  pidaw_mul #(.A_WIDTH(MW), .B_WIDTH(MW)) u_mul (
    .clk(clk), .rst(rst), .start(m_start), .a(m_a), .b(m_b),
    .done(m_done), .prod(m_prod)
  );

  pidaw_div #(.VALUE_WIDTH(VW), .NUM_WIDTH(PW), .DEN_WIDTH(MW)) u_div (
    .clk(clk), .rst(rst), .ctl(dctl), .num(d_num), .den(d_den),
    .done(d_done), .quo(d_quo)
  );

  function automatic logic [MW-1:0] mag_w(input logic signed [VW+1:0] v);
    logic [VW+1:0] u;
    u = v[VW+1] ? -v : v;
    return MW'(u);
  endfunction

  function automatic logic signed [VW-1:0] clampv(input logic signed [WW-1:0] v,
                                                  input logic lim,
                                                  input logic signed [VW-1:0] h,
                                                  input logic signed [VW-1:0] l);
    logic signed [WW-1:0] hw, lw;
    hw = lim ? WW'(h) : VMAX_W;
    lw = lim ? WW'(l) : VMIN_W;
    if (v > hw) return hw[VW-1:0];
    if (v < lw) return lw[VW-1:0];
    return v[VW-1:0];
  endfunction

  assign hi       = (upper_limit > lower_limit) ? upper_limit : lower_limit;
  assign lo       = (upper_limit > lower_limit) ? lower_limit : upper_limit;
  assign limiting = (hi != lo);
  assign aw       = anti_windup && limiting;
  assign err_raw  = (VW+1)'(setpoint) - (VW+1)'(measurement);
  assign err_sat  = (err_raw > (VW+1)'(VMAX_W)) ? VMAX_W[VW-1:0] :
                    (err_raw < (VW+1)'(VMIN_W)) ? VMIN_W[VW-1:0] : err_raw[VW-1:0];
  assign sum_w    = WW'(p) + WW'(integral_sum) + WW'(d);
  assign isum_w   = WW'(integral_sum) + WW'(d_quo);
  assign drive_w  = sum_w;
  assign esum     = (VW+1)'(err) + (VW+1)'(previous_error);

  assign in_ready = (state == ST_IDLE);

  // Which operands feed the serial units in each state.
  logic signed [VW+1:0] mul_x, mul_y;
  logic [MW-1:0]        div_den;
  always_comb begin
    mul_x   = (VW+2)'(kp);
    mul_y   = (VW+2)'(err);
    div_den = MW'(1) << FRACTION_BITS;
    case (state)
      ST_P_MUL:  begin mul_y = (VW+2)'(err); end
      ST_KD_MUL: begin mul_y = (VW+2)'($signed({1'b0, derivative_time})); end
      ST_D_DIV:  begin mul_x = (VW+2)'(kd); mul_y = (VW+2)'(de);
                   div_den = MW'(el) << FRACTION_BITS; end
      ST_X_MUL:  begin mul_y = (VW+2)'(esum); end
      ST_I_DIV:  begin mul_x = x; mul_y = (VW+2)'($signed({1'b0, el}));
                   div_den = den_r; end
      default:   begin end
    endcase
  end

  // Integral term: Ti * 2e6 first, then |x| * elapsed. Derivative term:
  // |kd| * |de| first, then that product times 1e6.
  always_comb begin
    m_a = mag_w(mul_x);
    m_b = mag_w(mul_y);
    if (state == ST_I_DIV && phase == 2'd0) begin
      m_a = MW'(integral_time);
      m_b = TWO_MEGA;
    end else if (state == ST_D_DIV && phase == 2'd1) begin
      m_a = m_prod[MW-1:0];
      m_b = MEGA;
    end
  end

  // Sequencer: each term runs phase 0 (multiply), 1 (multiply wait), optionally
  // 3 (second multiply), then 2 (divide wait).
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic term_done;
  logic two_mul;
  assign term_done = (phase == 2'd2) && d_done;
  assign two_mul   = (state == ST_D_DIV) || (state == ST_I_DIV);

  always_comb begin
    state_next = state;
    m_start    = 1'b0;
    dctl.start = 1'b0;
    dctl.neg   = sign_r;
    d_num      = m_prod;
    d_den      = div_den;
    case (state)
      ST_IDLE: begin
        if (in_valid && !func) state_next = ST_P_MUL;
      end
      ST_P_MUL, ST_KD_MUL, ST_D_DIV, ST_X_MUL, ST_I_DIV: begin
        m_start = (phase == 2'd0);
        if (phase == 2'd1 && m_done) begin
          if (two_mul) m_start = 1'b1;
          else dctl.start = 1'b1;
        end
        if (phase == 2'd3 && m_done) begin
          dctl.start = 1'b1;
          if (state == ST_I_DIV) d_num = m_prod << FRACTION_BITS;
        end
        if (term_done) begin
          case (state)
            ST_P_MUL:  state_next = (have_previous && derivative_time != '0 && el != '0)
                                    ? ST_KD_MUL : ST_CORR;
            ST_KD_MUL: state_next = ST_D_DIV;
            ST_D_DIV:  state_next = ST_CORR;
            ST_X_MUL:  state_next = ST_I_DIV;
            ST_I_DIV:  state_next = ST_I_UPD;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_CORR: begin
        state_next = (have_previous && integral_time != '0 && el != '0) ? ST_X_MUL : ST_DRIVE;
      end
      ST_I_UPD: state_next = ST_DRIVE;
      ST_DRIVE: state_next = ST_OUT;
      ST_OUT:   if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Phase counter and sign of the running term.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
    end else if (state_next != state) begin
      phase <= 2'd0;
    end else if (phase == 2'd0 && m_start) begin
      phase <= 2'd1;
    end else if (phase == 2'd1 && m_done) begin
      phase <= two_mul ? 2'd3 : 2'd2;
    end else if (phase == 2'd3 && m_done) begin
      phase <= 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (m_start && phase == 2'd0) sign_r <= mul_x[VW+1] ^ mul_y[VW+1];
    if (state == ST_I_DIV && phase == 2'd1 && m_done) den_r <= m_prod[MW-1:0];
  end

  // Datapath and state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      kp                  <= VW'(1) <<< FRACTION_BITS;
      integral_time       <= '0;
      derivative_time     <= '0;
      upper_limit         <= '0;
      lower_limit         <= '0;
      anti_windup         <= 1'b0;
      have_previous       <= 1'b0;
      previous_error      <= '0;
      previous_correction <= '0;
      integral_sum        <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (cfg_we && cfg_index <= REG_ANTI_WINDUP) begin
        case (cfg_index)
          REG_KP:              kp              <= cfg_data;
          REG_INTEGRAL_TIME:   integral_time   <= cfg_data[VW-2:0];
          REG_DERIVATIVE_TIME: derivative_time <= cfg_data[VW-2:0];
          REG_UPPER_LIMIT:     upper_limit     <= cfg_data;
          REG_LOWER_LIMIT:     lower_limit     <= cfg_data;
          REG_ANTI_WINDUP:     anti_windup     <= cfg_data[0];
          default:             begin end
        endcase
        have_previous       <= 1'b0;
        previous_error      <= '0;
        previous_correction <= '0;
      end
      if (state == ST_IDLE && in_valid && func) begin
        have_previous       <= 1'b0;
        previous_error      <= '0;
        previous_correction <= '0;
        integral_sum        <= '0;
      end
      if (state == ST_I_DIV && term_done) begin
        integral_sum <= clampv(isum_w, limiting, hi, lo);
      end
      if (state == ST_DRIVE) begin
        drive               <= clampv(drive_w, limiting, hi, lo);
        proportional        <= p;
        integral            <= integral_sum;
        derivative          <= d;
        correction          <= corr;
        have_previous       <= 1'b1;
        previous_error      <= err;
        previous_correction <= corr;
        out_valid           <= 1'b1;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid && !func) begin
      err  <= err_sat;
      el   <= elapsed_us;
      d    <= '0;
      corr <= '0;
    end
    if (term_done) begin
      case (state)
        ST_P_MUL:  p  <= d_quo;
        ST_KD_MUL: begin
          kd <= d_quo;
          de <= (VW+1)'(err) - (VW+1)'(previous_error);
        end
        ST_D_DIV:  d  <= d_quo;
        ST_X_MUL:  x  <= (VW+2)'(d_quo) - (VW+2)'(corr) - (VW+2)'(previous_correction);
        default:   begin end
      endcase
    end
    if (state == ST_CORR && aw) begin
      if (sum_w > WW'(hi)) corr <= clampv(sum_w - WW'(hi), 1'b0, hi, lo);
      else if (sum_w < WW'(lo)) corr <= clampv(sum_w - WW'(lo), 1'b0, hi, lo);
    end
  end

endmodule

/* sv/pidaw_checker.sv */
// Port-level checker for the PID controller, bound to the top level.
module pidaw_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  // Busy while a result waits.
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  // A result holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  // A result is followed by a free input side after transfer.
  a_ready_after: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> in_ready) else $error("not ready after transfer");

  // Reset leaves no pending result.
  a_reset_clean: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("result after reset");

endmodule

bind pid_controller_antiwindup pidaw_checker u_pidaw_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready)
);
